### hw/rtl/edge_triggered_pulse_rules_unit_macros.svh
// assertion macros for the edge triggered pulse rules unit
// used by the checker file; no other dependencies
`ifndef EDGE_TRIGGERED_PULSE_RULES_UNIT_MACROS_SVH
`define EDGE_TRIGGERED_PULSE_RULES_UNIT_MACROS_SVH

// same-cycle implication
`define ETPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etpr assertion failed");

// next-cycle implication
`define ETPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etpr assertion failed");

`endif

### hw/rtl/etpr_pkg.sv
// shared types and field widths for the edge triggered pulse rules unit
// no dependencies
package etpr_pkg;

  localparam int unsigned RULE_W  = 4;
  localparam int unsigned SW_W    = 6;
  localparam int unsigned DRV_W   = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned TP_W    = 8;
  localparam int unsigned SWVEC_W = 64;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SETUP   = 2'd1,
    REQ_ENABLE  = 2'd2,
    REQ_DISABLE = 2'd3
  } req_e;

  typedef struct packed {
    logic              edge_pos;
    logic [SW_W-1:0]   switch_idx;
    logic [DRV_W-1:0]  driver;
    logic [TIME_W-1:0] holdoff;
    logic [TIME_W-1:0] pulse;
    logic [TIME_W-1:0] pwm_on;
    logic [TIME_W-1:0] pwm_off;
  } rule_cfg_t;

  typedef struct packed {
    logic [RULE_W-1:0] rule;
    logic [DRV_W-1:0]  driver;
    logic [TIME_W-1:0] pulse;
    logic [TIME_W-1:0] pwm_on;
    logic [TIME_W-1:0] pwm_off;
  } fire_t;

  typedef struct packed {
    logic push;
    logic flush;
  } ob_req_t;

  typedef struct packed {
    logic stall;
    logic pend_valid;
    logic out_free;
  } ob_sts_t;

endpackage

### hw/rtl/etpr_rule_mem.sv
// rule setup memory, one write and one registered read port
// unwritten entries read as zero; depends on etpr_pkg
module etpr_rule_mem #(
  parameter int unsigned NUM_RULES = 16
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           we_i,
  input  logic [((NUM_RULES > 1) ? $clog2(NUM_RULES) : 1)-1:0] waddr_i,
  input  etpr_pkg::rule_cfg_t                            wdata_i,
  input  logic [((NUM_RULES > 1) ? $clog2(NUM_RULES) : 1)-1:0] raddr_i,
  output etpr_pkg::rule_cfg_t                            rdata_o
);

  etpr_pkg::rule_cfg_t mem [NUM_RULES];
  etpr_pkg::rule_cfg_t mem_rd_q;
  logic [NUM_RULES-1:0] written_q;
  logic                 vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    mem_rd_q <= mem[raddr_i];
  end

  // per-entry written bits stand in for clearing the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      vld_rd_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      vld_rd_q <= written_q[raddr_i];
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : '0;

endmodule

### hw/rtl/etpr_cnt_mem.sv
// hold-off counter memory, one write and one registered read port
// depends on etpr_pkg
module etpr_cnt_mem #(
  parameter int unsigned NUM_RULES = 16
) (
  input  logic                                                 clk_i,
  input  logic                                                 we_i,
  input  logic [((NUM_RULES > 1) ? $clog2(NUM_RULES) : 1)-1:0] waddr_i,
  input  logic [etpr_pkg::TIME_W-1:0]                          wdata_i,
  input  logic [((NUM_RULES > 1) ? $clog2(NUM_RULES) : 1)-1:0] raddr_i,
  output logic [etpr_pkg::TIME_W-1:0]                          rdata_o
);

  logic [etpr_pkg::TIME_W-1:0] mem [NUM_RULES];
  logic [etpr_pkg::TIME_W-1:0] rd_q;

  // a counter is only read while its rule is triggered, and the trigger
  // writes it first, so no clear is needed
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

### hw/rtl/etpr_out_buf.sv
// result staging: one pending fire held back until the next fire or the end
// of the tick decides its last flag, then an output register; uses etpr_pkg
module etpr_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  etpr_pkg::ob_req_t   req_i,
  input  etpr_pkg::fire_t     fire_i,
  output etpr_pkg::ob_sts_t   sts_o,
  output logic                valid_o,
  input  logic                ready_i,
  output etpr_pkg::fire_t     fire_o,
  output logic                last_o
);

  etpr_pkg::fire_t pend_q;
  etpr_pkg::fire_t out_q;
  logic            pend_valid_q, pend_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            last_q;
  logic            out_free, stall, push_ok, load_mid, load_last;

  assign out_free  = !out_valid_q || ready_i;
  assign stall     = req_i.push && pend_valid_q && !out_free;
  assign push_ok   = req_i.push && !stall;
  assign load_mid  = push_ok && pend_valid_q;
  assign load_last = req_i.flush && pend_valid_q && out_free;

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (push_ok) begin
      pend_valid_d = 1'b1;
    end else if (load_last) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_mid || load_last) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      pend_q <= fire_i;
    end
    if (load_mid || load_last) begin
      out_q  <= pend_q;
      last_q <= load_last;
    end
  end

  assign sts_o.stall      = stall;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;
  assign valid_o          = out_valid_q;
  assign fire_o           = out_q;
  assign last_o           = last_q;

endmodule

### hw/rtl/edge_triggered_pulse_rules_unit.sv
// top level of the edge triggered pulse rules unit
// depends on etpr_pkg, etpr_rule_mem, etpr_cnt_mem, etpr_out_buf
//
// A table of NUM_RULES quick-fire rules, each tying one switch to one driver.
// Setup, enable and disable requests finish at once and give no result; a
// rule id beyond the table is ignored. A tick request walks the table one rule
// per cycle while the output does not stall, through the rule and counter
// memories (one read port each); a tick keeps the input busy until the walk
// ends and any final beat is in the output register. Fire beats leave in
// rule order and the final one of a tick carries last_fire. The output
// register lets a new request be taken while the final beat still waits. The
// tick period register may be written at any time the block is idle. The
// table reads as cleared right after reset; no clearing pass is needed.
module edge_triggered_pulse_rules_unit #(
  parameter int unsigned NUM_RULES    = 16,
  parameter int unsigned NUM_SWITCHES = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [etpr_pkg::TP_W-1:0]             cfg_tick_period_i,
  // requests
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            req_type_i,
  input  logic [etpr_pkg::RULE_W-1:0]           rule_id_i,
  input  logic [etpr_pkg::SW_W-1:0]             switch_index_i,
  input  logic [etpr_pkg::DRV_W-1:0]            driver_index_i,
  input  logic [etpr_pkg::TIME_W-1:0]           holdoff_time_i,
  input  logic [etpr_pkg::TIME_W-1:0]           pulse_time_i,
  input  logic [etpr_pkg::TIME_W-1:0]           pwm_high_i,
  input  logic [etpr_pkg::TIME_W-1:0]           pwm_low_i,
  input  logic                                  positive_edge_i,
  input  logic [etpr_pkg::SWVEC_W-1:0]          debounced_switches_i,
  input  logic [etpr_pkg::SWVEC_W-1:0]          toggled_switches_i,
  // fire commands
  output logic                                  fire_valid_o,
  input  logic                                  fire_ready_i,
  output logic [etpr_pkg::RULE_W-1:0]           fired_rule_o,
  output logic [etpr_pkg::DRV_W-1:0]            fire_driver_o,
  output logic [etpr_pkg::TIME_W-1:0]           fire_pulse_time_o,
  output logic [etpr_pkg::TIME_W-1:0]           fire_pwm_high_o,
  output logic [etpr_pkg::TIME_W-1:0]           fire_pwm_low_o,
  output logic                                  last_fire_o
);

  localparam int unsigned RIDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_RULES + 1);
  localparam int unsigned SIDX_W = $clog2(NUM_SWITCHES);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [etpr_pkg::TP_W-1:0]    tick_period_q;
  logic [NUM_SWITCHES-1:0]      deb_q, tog_q;
  logic [CNT_W-1:0]             rd_cnt_q, rd_cnt_d;
  logic                         s1_valid_q, s1_valid_d;
  logic [RIDX_W-1:0]            s1_idx_q;
  logic [NUM_RULES-1:0]         enabled_q, enabled_d;
  logic [NUM_RULES-1:0]         triggered_q, triggered_d;

  etpr_pkg::req_e               req;
  logic                         in_acc, tick_acc, id_ok, setup_we;
  logic [RIDX_W-1:0]            cmd_idx;
  etpr_pkg::rule_cfg_t          setup_cfg;

  etpr_pkg::rule_cfg_t          rule;
  logic [etpr_pkg::TIME_W-1:0]  cnt;
  logic [etpr_pkg::TIME_W-1:0]  tp_ext;
  logic [etpr_pkg::TIME_W-1:0]  cnt_wdata;
  logic                         cnt_we;
  logic [RIDX_W-1:0]            rd_addr;
  logic [SIDX_W-1:0]            sw_pos;
  logic                         sw_ok, s1_live, s1_trg, fire, stall, commit;
  logic                         issue, s1_done;

  etpr_pkg::ob_req_t            ob_req;
  etpr_pkg::ob_sts_t            ob_sts;
  etpr_pkg::fire_t              fire_new, fire_out;

  // request decode
  assign req        = etpr_pkg::req_e'(req_type_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && (req == etpr_pkg::REQ_TICK);
  assign id_ok      = (32'(rule_id_i) < NUM_RULES);
  assign cmd_idx    = RIDX_W'(rule_id_i);
  assign setup_we   = in_acc && (req == etpr_pkg::REQ_SETUP) && id_ok;

  assign setup_cfg.edge_pos   = positive_edge_i;
  assign setup_cfg.switch_idx = switch_index_i;
  assign setup_cfg.driver     = driver_index_i;
  assign setup_cfg.holdoff    = holdoff_time_i;
  assign setup_cfg.pulse      = pulse_time_i;
  assign setup_cfg.pwm_on     = pwm_high_i;
  assign setup_cfg.pwm_off    = pwm_low_i;

  assign cfg_ready_o = 1'b1;

  // evaluation of the rule whose memory read has returned
  assign s1_trg  = triggered_q[s1_idx_q];
  assign s1_live = (state_q == ST_WALK) && s1_valid_q && enabled_q[s1_idx_q];
  assign sw_ok   = (32'(rule.switch_idx) < NUM_SWITCHES);
  assign sw_pos  = SIDX_W'(rule.switch_idx);
  assign fire    = s1_live && !s1_trg && sw_ok && tog_q[sw_pos]
                   && (deb_q[sw_pos] == rule.edge_pos);
  assign stall   = ob_sts.stall;
  assign commit  = s1_live && !stall;

  assign tp_ext = etpr_pkg::TIME_W'(tick_period_q);
  assign cnt_we = commit && (fire || (s1_trg && (cnt != '0)));

  always_comb begin
    if (fire) begin
      cnt_wdata = rule.holdoff;
    end else if (cnt <= tp_ext) begin
      cnt_wdata = '0;
    end else begin
      cnt_wdata = cnt - tp_ext;
    end
  end

  // walk sequencing; a stalled rule is read again so its data stays current
  assign issue   = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(NUM_RULES)) && !stall;
  assign rd_addr = stall ? s1_idx_q : rd_cnt_q[RIDX_W-1:0];
  assign s1_done = (state_q == ST_WALK) && s1_valid_q && !stall
                   && (s1_idx_q == RIDX_W'(NUM_RULES - 1));

  assign rd_cnt_d   = tick_acc ? '0 : (issue ? rd_cnt_q + 1'b1 : rd_cnt_q);
  assign s1_valid_d = issue || (s1_valid_q && stall);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (s1_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!ob_sts.pend_valid || ob_sts.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // rule flags
  always_comb begin
    enabled_d   = enabled_q;
    triggered_d = triggered_q;
    if (in_acc && id_ok) begin
      unique case (req)
        etpr_pkg::REQ_SETUP: begin
          enabled_d[cmd_idx]   = 1'b1;
          triggered_d[cmd_idx] = 1'b0;
        end
        etpr_pkg::REQ_ENABLE: begin
          enabled_d[cmd_idx] = 1'b1;
        end
        etpr_pkg::REQ_DISABLE: begin
          enabled_d[cmd_idx]   = 1'b0;
          triggered_d[cmd_idx] = 1'b0;
        end
        etpr_pkg::REQ_TICK: begin
        end
      endcase
    end
    if (commit) begin
      if (fire) begin
        triggered_d[s1_idx_q] = 1'b1;
      end else if (s1_trg && (cnt == '0)) begin
        // re-arm tick, no edge check until the next tick
        triggered_d[s1_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_period_q <= etpr_pkg::TP_W'(1);
      rd_cnt_q      <= '0;
      s1_valid_q    <= 1'b0;
      enabled_q     <= '0;
      triggered_q   <= '0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      s1_valid_q  <= s1_valid_d;
      enabled_q   <= enabled_d;
      triggered_q <= triggered_d;
      if (cfg_valid_i) begin
        tick_period_q <= cfg_tick_period_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      deb_q <= debounced_switches_i[NUM_SWITCHES-1:0];
      tog_q <= toggled_switches_i[NUM_SWITCHES-1:0];
    end
    if (issue) begin
      s1_idx_q <= rd_cnt_q[RIDX_W-1:0];
    end
  end

  etpr_rule_mem #(
    .NUM_RULES (NUM_RULES)
  ) u_rule_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (setup_we),
    .waddr_i (cmd_idx),
    .wdata_i (setup_cfg),
    .raddr_i (rd_addr),
    .rdata_o (rule)
  );

  etpr_cnt_mem #(
    .NUM_RULES (NUM_RULES)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (s1_idx_q),
    .wdata_i (cnt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (cnt)
  );

  assign ob_req.push      = fire;
  assign ob_req.flush     = (state_q == ST_FLUSH);
  assign fire_new.rule    = etpr_pkg::RULE_W'(s1_idx_q);
  assign fire_new.driver  = rule.driver;
  assign fire_new.pulse   = rule.pulse;
  assign fire_new.pwm_on  = rule.pwm_on;
  assign fire_new.pwm_off = rule.pwm_off;

  etpr_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ob_req),
    .fire_i  (fire_new),
    .sts_o   (ob_sts),
    .valid_o (fire_valid_o),
    .ready_i (fire_ready_i),
    .fire_o  (fire_out),
    .last_o  (last_fire_o)
  );

  assign fired_rule_o      = fire_out.rule;
  assign fire_driver_o     = fire_out.driver;
  assign fire_pulse_time_o = fire_out.pulse;
  assign fire_pwm_high_o   = fire_out.pwm_on;
  assign fire_pwm_low_o    = fire_out.pwm_off;

endmodule

### hw/rtl/etpr_checker.sv
// port-level checks for the edge triggered pulse rules unit, bound to the top
// depends on etpr_pkg and edge_triggered_pulse_rules_unit_macros.svh
`include "edge_triggered_pulse_rules_unit_macros.svh"

module etpr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [1:0]                  req_type_i,
  input logic                        fire_valid_o,
  input logic                        fire_ready_i,
  input logic [etpr_pkg::RULE_W-1:0] fired_rule_o,
  input logic [etpr_pkg::DRV_W-1:0]  fire_driver_o,
  input logic                        last_fire_o
);

  // a waiting fire beat holds
  `ETPR_ASSERT_NXT(a_fire_hold, clk_i, rst_ni, fire_valid_o && !fire_ready_i, fire_valid_o && $stable(fired_rule_o) && $stable(fire_driver_o) && $stable(last_fire_o))

  // a tick keeps the request side busy while the table is walked
  `ETPR_ASSERT_NXT(a_tick_busy, clk_i, rst_ni, in_valid_i && in_ready_o && req_type_i == etpr_pkg::REQ_TICK, !in_ready_o)

  // rule commands finish in the cycle they are taken
  `ETPR_ASSERT_NXT(a_cmd_done, clk_i, rst_ni, in_valid_i && in_ready_o && req_type_i != etpr_pkg::REQ_TICK, in_ready_o)

  // while a non-final beat is shown the tick is still in progress
  `ETPR_ASSERT_IMP(a_last_pending, clk_i, rst_ni, fire_valid_o && !last_fire_o, !in_ready_o)

endmodule

bind edge_triggered_pulse_rules_unit etpr_checker u_etpr_checker (.*);

### tb/sv/edge_triggered_pulse_rules_unit_tb.sv
`timescale 1ns / 100ps
// testbench for edge_triggered_pulse_rules_unit: directed rule tests, then random traffic
// depends on etpr_pkg and the unit's rtl; checks every fire beat against an internal rule table
module edge_triggered_pulse_rules_unit_tb;

  localparam int unsigned NUM_RULES      = 16;
  localparam int unsigned NUM_SWITCHES   = 64;
  localparam int unsigned SETTLE_CYCLES  = NUM_RULES + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTED   = 10;
  localparam int unsigned PHASE_ITEMS    = 86;

  localparam int unsigned RULE_W  = etpr_pkg::RULE_W;
  localparam int unsigned SW_W    = etpr_pkg::SW_W;
  localparam int unsigned DRV_W   = etpr_pkg::DRV_W;
  localparam int unsigned TIME_W  = etpr_pkg::TIME_W;
  localparam int unsigned TP_W    = etpr_pkg::TP_W;
  localparam int unsigned SWVEC_W = etpr_pkg::SWVEC_W;

  typedef struct {
    etpr_pkg::req_e     kind;
    logic [RULE_W-1:0]  rule;
    logic [SW_W-1:0]    switch_idx;
    logic [DRV_W-1:0]   driver;
    logic [TIME_W-1:0]  holdoff;
    logic [TIME_W-1:0]  pulse;
    logic [TIME_W-1:0]  pwm_on;
    logic [TIME_W-1:0]  pwm_off;
    logic               rising;
    logic [SWVEC_W-1:0] levels;
    logic [SWVEC_W-1:0] toggles;
  } request_t;

  typedef struct {
    etpr_pkg::fire_t cmd;
    logic            last;
  } fire_beat_t;

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                cfg_valid_i          = 1'b0;
  logic                cfg_ready_o;
  logic [TP_W-1:0]     cfg_tick_period_i    = '0;
  logic                in_valid_i           = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i           = '0;
  logic [RULE_W-1:0]   rule_id_i            = '0;
  logic [SW_W-1:0]     switch_index_i       = '0;
  logic [DRV_W-1:0]    driver_index_i       = '0;
  logic [TIME_W-1:0]   holdoff_time_i       = '0;
  logic [TIME_W-1:0]   pulse_time_i         = '0;
  logic [TIME_W-1:0]   pwm_high_i           = '0;
  logic [TIME_W-1:0]   pwm_low_i            = '0;
  logic                positive_edge_i      = 1'b0;
  logic [SWVEC_W-1:0]  debounced_switches_i = '0;
  logic [SWVEC_W-1:0]  toggled_switches_i   = '0;
  logic                fire_valid_o;
  logic                fire_ready_i         = 1'b0;
  logic [RULE_W-1:0]   fired_rule_o;
  logic [DRV_W-1:0]    fire_driver_o;
  logic [TIME_W-1:0]   fire_pulse_time_o;
  logic [TIME_W-1:0]   fire_pwm_high_o;
  logic [TIME_W-1:0]   fire_pwm_low_o;
  logic                last_fire_o;

  // rule table as the testbench sees it
  logic [TP_W-1:0]   period_m;
  logic              en_m    [NUM_RULES];
  logic              trig_m  [NUM_RULES];
  logic              pos_m   [NUM_RULES];
  logic [SW_W-1:0]   sw_m    [NUM_RULES];
  logic [DRV_W-1:0]  drv_m   [NUM_RULES];
  logic [TIME_W-1:0] hold_m  [NUM_RULES];
  logic [TIME_W-1:0] pulse_m [NUM_RULES];
  logic [TIME_W-1:0] on_m    [NUM_RULES];
  logic [TIME_W-1:0] off_m   [NUM_RULES];
  logic [TIME_W-1:0] cnt_m   [NUM_RULES];

  fire_beat_t  pending_fires[$];
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned items_sent      = 0;
  int unsigned ticks_sent      = 0;
  int unsigned fires_checked   = 0;
  int unsigned cfg_writes      = 0;
  int unsigned mismatches      = 0;

  edge_triggered_pulse_rules_unit #(
    .NUM_RULES   (NUM_RULES),
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_tick_period_i   (cfg_tick_period_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .rule_id_i           (rule_id_i),
    .switch_index_i      (switch_index_i),
    .driver_index_i      (driver_index_i),
    .holdoff_time_i      (holdoff_time_i),
    .pulse_time_i        (pulse_time_i),
    .pwm_high_i          (pwm_high_i),
    .pwm_low_i           (pwm_low_i),
    .positive_edge_i     (positive_edge_i),
    .debounced_switches_i(debounced_switches_i),
    .toggled_switches_i  (toggled_switches_i),
    .fire_valid_o        (fire_valid_o),
    .fire_ready_i        (fire_ready_i),
    .fired_rule_o        (fired_rule_o),
    .fire_driver_o       (fire_driver_o),
    .fire_pulse_time_o   (fire_pulse_time_o),
    .fire_pwm_high_o     (fire_pwm_high_o),
    .fire_pwm_low_o      (fire_pwm_low_o),
    .last_fire_o         (last_fire_o)
  );

  always #6 clk_i = ~clk_i;

  // updates the rule table for one request and queues the fire beats it causes
  function automatic void apply_request(request_t req);
    fire_beat_t held;
    bit         have_held;
    have_held = 1'b0;
    case (req.kind)
      etpr_pkg::REQ_SETUP: begin
        sw_m[req.rule]    = req.switch_idx;
        drv_m[req.rule]   = req.driver;
        hold_m[req.rule]  = req.holdoff;
        pulse_m[req.rule] = req.pulse;
        on_m[req.rule]    = req.pwm_on;
        off_m[req.rule]   = req.pwm_off;
        pos_m[req.rule]   = req.rising;
        trig_m[req.rule]  = 1'b0;
        en_m[req.rule]    = 1'b1;
      end
      etpr_pkg::REQ_ENABLE: en_m[req.rule] = 1'b1;
      etpr_pkg::REQ_DISABLE: begin
        en_m[req.rule]   = 1'b0;
        trig_m[req.rule] = 1'b0;
      end
      default: begin
        for (int r = 0; r < NUM_RULES; r++) begin
          if (!en_m[r]) continue;
          if (trig_m[r]) begin
            // counter already at zero: re-arm only, no edge check this tick
            if (cnt_m[r] == '0) trig_m[r] = 1'b0;
            else if (cnt_m[r] <= period_m) cnt_m[r] = '0;
            else cnt_m[r] = cnt_m[r] - period_m;
          end else if (req.toggles[sw_m[r]] && req.levels[sw_m[r]] == pos_m[r]) begin
            trig_m[r] = 1'b1;
            cnt_m[r]  = hold_m[r];
            if (have_held) pending_fires.push_back(held);
            held.cmd.rule    = RULE_W'(r);
            held.cmd.driver  = drv_m[r];
            held.cmd.pulse   = pulse_m[r];
            held.cmd.pwm_on  = on_m[r];
            held.cmd.pwm_off = off_m[r];
            held.last        = 1'b0;
            have_held        = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          pending_fires.push_back(held);
        end
      end
    endcase
  endfunction

  function automatic request_t random_request();
    request_t    req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    req.kind = pick < 55 ? etpr_pkg::REQ_TICK :
               pick < 80 ? etpr_pkg::REQ_SETUP :
               pick < 90 ? etpr_pkg::REQ_ENABLE : etpr_pkg::REQ_DISABLE;
    req.rule       = RULE_W'($urandom_range(0, NUM_RULES - 1));
    req.switch_idx = SW_W'($urandom_range(0, NUM_SWITCHES - 1));
    req.driver     = DRV_W'($urandom);
    // short hold-offs mostly, so rules re-arm and fire again
    req.holdoff    = TIME_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 6));
    req.pulse      = TIME_W'($urandom);
    req.pwm_on     = TIME_W'($urandom);
    req.pwm_off    = TIME_W'($urandom);
    req.rising     = 1'($urandom);
    req.levels     = {$urandom, $urandom};
    req.toggles    = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: begin
        req.toggles = '1;
        req.levels  = '1;
      end
      1: begin
        req.toggles = '1;
        req.levels  = '0;
      end
      2: req.toggles = '0;
      3: req.toggles = req.toggles & {$urandom, $urandom};
      default: ;
    endcase
    return req;
  endfunction

  function automatic request_t setup_request(logic [RULE_W-1:0] rule, logic [SW_W-1:0] sw,
                                             logic [DRV_W-1:0] drv, logic [TIME_W-1:0] hold,
                                             logic [TIME_W-1:0] pulse, logic [TIME_W-1:0] on,
                                             logic [TIME_W-1:0] off, logic rising);
    request_t req;
    req            = random_request();
    req.kind       = etpr_pkg::REQ_SETUP;
    req.rule       = rule;
    req.switch_idx = sw;
    req.driver     = drv;
    req.holdoff    = hold;
    req.pulse      = pulse;
    req.pwm_on     = on;
    req.pwm_off    = off;
    req.rising     = rising;
    return req;
  endfunction

  function automatic request_t tick_request(logic [SWVEC_W-1:0] levels,
                                            logic [SWVEC_W-1:0] toggles);
    request_t req;
    req         = random_request();
    req.kind    = etpr_pkg::REQ_TICK;
    req.levels  = levels;
    req.toggles = toggles;
    return req;
  endfunction

  function automatic request_t flag_request(etpr_pkg::req_e kind, logic [RULE_W-1:0] rule);
    request_t req;
    req      = random_request();
    req.kind = kind;
    req.rule = rule;
    return req;
  endfunction

  // valid stays high into the next request unless a gap is drawn
  task automatic send_request(request_t req);
    in_valid_i           <= 1'b1;
    req_type_i           <= req.kind;
    rule_id_i            <= req.rule;
    switch_index_i       <= req.switch_idx;
    driver_index_i       <= req.driver;
    holdoff_time_i       <= req.holdoff;
    pulse_time_i         <= req.pulse;
    pwm_high_i           <= req.pwm_on;
    pwm_low_i            <= req.pwm_off;
    positive_edge_i      <= req.rising;
    debounced_switches_i <= req.levels;
    toggled_switches_i   <= req.toggles;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(req);
    items_sent++;
    if (req.kind == etpr_pkg::REQ_TICK) ticks_sent++;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    // a tick that fires nothing may still be walking the table
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tick_period(logic [TP_W-1:0] value);
    cfg_valid_i       <= 1'b1;
    cfg_tick_period_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    period_m = value;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // field extremes, both polarities, last flag placement, wrong-level toggles
  task automatic test_setup_and_fire();
    send_request(setup_request(4'd0, 6'd0, 8'h00, 16'd2, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_request(setup_request(4'd15, 6'd63, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               1'b0));
    send_request(setup_request(4'd7, 6'd5, 8'h5A, 16'd0, 16'h1234, 16'hA5A5, 16'h5A5A, 1'b1));
    send_request(tick_request(64'h0000_0000_0000_0001, '1));
    send_request(tick_request(64'h0000_0000_0000_0020, 64'h0000_0000_0000_0020));
    send_request(tick_request('0, '0));
  endtask

  // re-arm tick, disable while triggered, enable of a never-configured rule, re-setup
  task automatic test_rearm_and_enable();
    send_request(tick_request('1, '1));
    send_request(tick_request('1, '1));
    send_request(flag_request(etpr_pkg::REQ_DISABLE, 4'd15));
    send_request(tick_request('0, '1));
    send_request(flag_request(etpr_pkg::REQ_ENABLE, 4'd15));
    send_request(tick_request('0, 64'h8000_0000_0000_0000));
    send_request(flag_request(etpr_pkg::REQ_ENABLE, 4'd3));
    send_request(tick_request('0, 64'h0000_0000_0000_0001));
    send_request(setup_request(4'd0, 6'd0, 8'h81, 16'd0, 16'h0001, 16'h8000, 16'h7FFF, 1'b1));
    send_request(tick_request(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001));
  endtask

  // zero period freezes a triggered rule, the largest one clears it at once
  task automatic test_tick_period_extremes();
    wait_idle();
    write_tick_period(8'd0);
    send_request(setup_request(4'd1, 6'd10, 8'h3C, 16'd5, 16'hBEEF, 16'h0F0F, 16'hF0F0, 1'b1));
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
    wait_idle();
    write_tick_period(8'd255);
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
    send_request(tick_request(64'h0000_0000_0000_0400, 64'h0000_0000_0000_0400));
  endtask

  task automatic test_random_traffic();
    logic [TP_W-1:0] periods [5];
    periods[0] = 8'd1;
    periods[1] = 8'd255;
    periods[2] = TP_W'($urandom_range(2, 254));
    periods[3] = TP_W'($urandom_range(1, 4));
    periods[4] = 8'd1;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      // last phase runs at full rate on both sides
      if (p == 4) begin
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
      end
      write_tick_period(periods[p]);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      fire_ready_i <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 12);
      fire_ready_i <= 1'b0;
    end else begin
      fire_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fire_beat_t want;
    if (rst_ni && fire_valid_o && fire_ready_i) begin
      if (pending_fires.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected fire beat rule %0d driver %0d", $realtime, fired_rule_o,
                   fire_driver_o);
      end else begin
        want = pending_fires.pop_front();
        fires_checked++;
        if (fired_rule_o !== want.cmd.rule || fire_driver_o !== want.cmd.driver ||
            fire_pulse_time_o !== want.cmd.pulse || fire_pwm_high_o !== want.cmd.pwm_on ||
            fire_pwm_low_o !== want.cmd.pwm_off || last_fire_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED) begin
            $display("%0t: fire beat mismatch", $realtime);
            $display("  expected rule %0d drv %0d pulse %h on %h off %h last %b",
                     want.cmd.rule, want.cmd.driver, want.cmd.pulse, want.cmd.pwm_on,
                     want.cmd.pwm_off, want.last);
            $display("  actual   rule %0d drv %0d pulse %h on %h off %h last %b",
                     fired_rule_o, fire_driver_o, fire_pulse_time_o, fire_pwm_high_o,
                     fire_pwm_low_o, last_fire_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (fire_valid_o && fire_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no beat accepted for %0d cycles, %0d fire beats outstanding", quiet_cycles,
               pending_fires.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    period_m = 8'd1;
    for (int r = 0; r < NUM_RULES; r++) begin
      en_m[r]    = 1'b0;
      trig_m[r]  = 1'b0;
      pos_m[r]   = 1'b0;
      sw_m[r]    = '0;
      drv_m[r]   = '0;
      hold_m[r]  = '0;
      pulse_m[r] = '0;
      on_m[r]    = '0;
      off_m[r]   = '0;
      cnt_m[r]   = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_setup_and_fire();
    test_rearm_and_enable();
    test_tick_period_extremes();
    test_random_traffic();
    wait_idle();
    $display("covered %0d requests including %0d ticks and %0d tick period writes",
             items_sent, ticks_sent, cfg_writes);
    $display("checked %0d fire beats, %0d mismatched", fires_checked, mismatches);
    if (mismatches == 0 && pending_fires.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
